// ===== design/assert_macros.svh =====
// Assertion macros used by the responder's job queue (arp_q).
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define ARP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("arp_responder: assertion failed");
// Checked on every rising edge, reset included.
`define ARP_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("arp_responder: assertion failed");
`else
`define ARP_ASSERT(label, clk, rst_n, prop)
`define ARP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== design/arp_pkg.sv =====
// Types, constants and the reply frame builder for the ARP responder.
// No dependencies; used by every module of the block and by the bench.
package arp_pkg;

	localparam int IDX_W     = 11;
	localparam int FRAME_MIN = 42;
	localparam int TX_IDX_W  = $clog2(FRAME_MIN);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [IDX_W-1:0] IDX_MAX = '1;

	localparam logic [47:0] MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
	localparam logic [15:0] HTYPE_ETH    = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
	localparam logic [7:0]  HLEN_ETH     = 8'd6;
	localparam logic [7:0]  PLEN_IPV4    = 8'd4;
	localparam logic [15:0] ARP_OP_REQ   = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY = 16'd2;

	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef struct packed {
		logic        req;
		logic [47:0] mac;
		logic [31:0] ip;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_chan_t;

	// Byte i of the 42-byte reply frame, first byte sent first.
	function automatic logic [7:0] reply_byte(input logic [TX_IDX_W-1:0] i,
			input logic [47:0] peer_mac, input logic [31:0] peer_ip,
			input logic [47:0] own_mac, input logic [31:0] own_ip);
		logic [FRAME_MIN*8-1:0] frame;
		logic [8:0] sh;
		frame = {peer_mac, own_mac, ETH_TYPE_ARP, HTYPE_ETH, PTYPE_IPV4,
			HLEN_ETH, PLEN_IPV4, ARP_OP_REPLY, own_mac, own_ip, peer_mac, peer_ip};
		sh = 9'((FRAME_MIN - 1 - int'(i)) * 8);
		return frame[sh +: 8];
	endfunction

endpackage

// ===== design/arp_ifs.sv =====
// Valid/ready channel interfaces for received bytes and for results.
// Depends on nothing.
interface arp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_end;

	modport source (output valid, output rx_byte, output frame_end, input ready);
	modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface arp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        run_last;
	logic [47:0] peer_mac;
	logic [31:0] peer_ip;

	modport source (output valid, output kind, output tx_byte, output run_last,
		output peer_mac, output peer_ip, input ready);
	modport sink (input valid, input kind, input tx_byte, input run_last,
		input peer_mac, input peer_ip, output ready);
endinterface

// ===== design/arp_responder.sv =====
// Top level of the ARP responder: configuration registers and the wiring
// of parser, job queue and transmit sequencer. Depends on arp_pkg, the
// channel interfaces, arp_rx, arp_q and arp_tx.
//
// Usage: received Ethernet frame bytes enter on the rx channel, one byte per
// transfer, starting at the destination MAC, with frame_end on the final
// byte. A frame addressed to this station (own MAC or broadcast), of type
// ARP, at least 42 bytes long and targeting own_ip is acted on: a request
// produces the 42-byte reply frame as 42 transfers of kind 0 on the tx
// channel, a reply produces a single kind 1 transfer with the sender's MAC
// and IP. run_last marks the final transfer of each run.
// The rx channel takes one byte every cycle while the job queue has room.
// A judged frame's job is written into the queue and then, when the output
// is free, into the output register, and the sequencer then delivers one
// result per cycle while tx.ready is high. Up to four judged frames wait in
// the job queue; when it is full, rx.ready falls until the sequencer starts
// the next job, so a stalled receiver on tx holds results in the output
// register and eventually back-pressures rx.
// Reset clears the frame position, the queue, the output valid flag and both
// address registers (all zero). The address registers sit on the APB port
// at byte addresses 0 (own_mac) and 8 (own_ip), 64-bit data, pready high.
module arp_responder (
	input  logic        clk,
	input  logic        arst_n,
	arp_in_if.sink      rx,
	arp_out_if.source   tx,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [47:0] own_mac_q;
	logic [31:0] own_ip_q;
	logic        wr_en;

	arp_pkg::job_chan_t push;
	arp_pkg::job_chan_t head;
	logic               room;
	logic               pop;

	// Registers are 64 bits apart, so bit 3 of the address selects one.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign prdata = paddr[3] ? {32'd0, own_ip_q} : {16'd0, own_mac_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
		end else if (wr_en) begin
			if (paddr[3]) begin
				own_ip_q <= pwdata[31:0];
			end else begin
				own_mac_q <= pwdata[47:0];
			end
		end
	end

	// Front end: parses every byte and pushes a job for each frame acted on.
	arp_rx u_rx (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.own_mac (own_mac_q),
		.own_ip  (own_ip_q),
		.room    (room),
		.push    (push)
	);

	// The queue lets the parser run ahead while a reply is still going out.
	arp_q u_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.head   (head),
		.pop    (pop)
	);

	// Back end: one result per cycle, while tx is ready, into a registered output stage.
	arp_tx u_tx (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.own_mac (own_mac_q),
		.own_ip  (own_ip_q),
		.tx      (tx)
	);

endmodule

// ===== design/arp_rx.sv =====
// Front end: captures ARP fields from received bytes and judges each frame.
// Depends on arp_pkg and arp_in_if.
module arp_rx (
	input  logic                clk,
	input  logic                arst_n,
	arp_in_if.sink              rx,
	input  logic [47:0]         own_mac,
	input  logic [31:0]         own_ip,
	input  logic                room,
	output arp_pkg::job_chan_t  push
);

	logic [arp_pkg::IDX_W-1:0] idx_q;
	logic [47:0] dst_q, smac_q;
	logic [15:0] eth_q, op_q;
	logic [31:0] sip_q, tip_q;
	logic [47:0] dst_n, smac_n;
	logic [15:0] eth_n, op_n;
	logic [31:0] sip_n, tip_n;
	logic        take, frame_ok;

	assign rx.ready = room;
	assign take     = rx.valid && room;

	// Field values including the byte now on the channel.
	always_comb begin
		dst_n  = dst_q;
		eth_n  = eth_q;
		op_n   = op_q;
		smac_n = smac_q;
		sip_n  = sip_q;
		tip_n  = tip_q;
		if (idx_q < 11'd6) begin
			dst_n = {dst_q[39:0], rx.rx_byte};
		end else if (idx_q == 11'd12 || idx_q == 11'd13) begin
			eth_n = {eth_q[7:0], rx.rx_byte};
		end else if (idx_q == 11'd20 || idx_q == 11'd21) begin
			op_n = {op_q[7:0], rx.rx_byte};
		end else if (idx_q >= 11'd22 && idx_q < 11'd28) begin
			smac_n = {smac_q[39:0], rx.rx_byte};
		end else if (idx_q >= 11'd28 && idx_q < 11'd32) begin
			sip_n = {sip_q[23:0], rx.rx_byte};
		end else if (idx_q >= 11'd38 && idx_q < 11'd42) begin
			tip_n = {tip_q[23:0], rx.rx_byte};
		end
	end

	assign frame_ok = eth_n == arp_pkg::ETH_TYPE_ARP
		&& (dst_n == own_mac || dst_n == arp_pkg::MAC_BCAST)
		&& idx_q >= arp_pkg::IDX_W'(arp_pkg::FRAME_MIN - 1)
		&& tip_n == own_ip;

	always_comb begin
		push.valid   = take && rx.frame_end && frame_ok
			&& (op_n == arp_pkg::ARP_OP_REQ || op_n == arp_pkg::ARP_OP_REPLY);
		push.job.req = op_n == arp_pkg::ARP_OP_REQ;
		push.job.mac = smac_n;
		push.job.ip  = sip_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			if (rx.frame_end) begin
				idx_q <= '0;
			end else if (idx_q != arp_pkg::IDX_MAX) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dst_q  <= dst_n;
			eth_q  <= eth_n;
			op_q   <= op_n;
			smac_q <= smac_n;
			sip_q  <= sip_n;
			tip_q  <= tip_n;
		end
	end

endmodule

// ===== design/arp_q.sv =====
// Short job queue between the frame parser and the transmit sequencer.
// Depends on arp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module arp_q (
	input  logic               clk,
	input  logic               arst_n,
	input  arp_pkg::job_chan_t push,
	output logic               room,
	output arp_pkg::job_chan_t head,
	input  logic               pop
);

	arp_pkg::job_t                entries_q [arp_pkg::QDEPTH];
	logic [arp_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [arp_pkg::QCNT_W-1:0]   count_q;

	assign room       = count_q != arp_pkg::QCNT_W'(arp_pkg::QDEPTH);
	assign head.valid = count_q != '0;
	assign head.job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.job;
		end
	end

	`ARP_ASSERT(a_push_has_room, clk, arst_n, push.valid |-> room)
	`ARP_ASSERT(a_pop_not_empty, clk, arst_n, pop |-> count_q != '0)
	`ARP_ASSERT_ALWAYS(a_count_bound, clk, count_q <= arp_pkg::QCNT_W'(arp_pkg::QDEPTH))
	`ARP_ASSERT(a_count_rise, clk, arst_n,
		(push.valid && !pop) |=> count_q == arp_pkg::QCNT_W'($past(count_q) + 1'b1))

endmodule

// ===== design/arp_tx.sv =====
// Back end: turns queued jobs into reply frame bytes or address reports.
// Depends on arp_pkg and arp_out_if.
module arp_tx (
	input  logic               clk,
	input  logic               arst_n,
	input  arp_pkg::job_chan_t head,
	output logic               pop,
	input  logic [47:0]        own_mac,
	input  logic [31:0]        own_ip,
	arp_out_if.source          tx
);

	logic                         active_q;
	logic [arp_pkg::TX_IDX_W-1:0] idx_q;
	logic [47:0]                  mac_q;
	logic [31:0]                  ip_q;
	logic                         out_valid_q;
	logic                         kind_q, last_q;
	logic [7:0]                   byte_q;
	logic [47:0]                  pmac_q;
	logic [31:0]                  pip_q;

	logic                         load, emit, is_last;
	logic [arp_pkg::TX_IDX_W-1:0] cur_idx;
	logic [47:0]                  cur_mac;
	logic [31:0]                  cur_ip;
	logic                         cur_req;

	// A new job is started straight from the queue head, so a reply runs
	// at one byte per cycle while tx.ready is high, with no bubble between jobs.
	assign load    = !out_valid_q || tx.ready;
	assign emit    = load && (active_q || head.valid);
	assign pop     = load && !active_q && head.valid;
	assign cur_idx = active_q ? idx_q : '0;
	assign cur_mac = active_q ? mac_q : head.job.mac;
	assign cur_ip  = active_q ? ip_q : head.job.ip;
	assign cur_req = active_q || head.job.req;
	assign is_last = cur_idx == arp_pkg::TX_IDX_W'(arp_pkg::FRAME_MIN - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= emit;
			end
			if (emit && cur_req) begin
				active_q <= !is_last;
				idx_q    <= cur_idx + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mac_q <= head.job.mac;
			ip_q  <= head.job.ip;
		end
		if (emit) begin
			if (cur_req) begin
				kind_q <= arp_pkg::KIND_BYTE;
				byte_q <= arp_pkg::reply_byte(cur_idx, cur_mac, cur_ip, own_mac, own_ip);
				last_q <= is_last;
				pmac_q <= '0;
				pip_q  <= '0;
			end else begin
				kind_q <= arp_pkg::KIND_REPORT;
				byte_q <= '0;
				last_q <= 1'b1;
				pmac_q <= cur_mac;
				pip_q  <= cur_ip;
			end
		end
	end

	assign tx.valid    = out_valid_q;
	assign tx.kind     = kind_q;
	assign tx.tx_byte  = byte_q;
	assign tx.run_last = last_q;
	assign tx.peer_mac = pmac_q;
	assign tx.peer_ip  = pip_q;

endmodule

// ===== bench/arp_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the ARP responder: watches the byte, result and register
// channels, predicts the results and compares them. Depends on arp_pkg and arp_ifs.
module arp_checker
	import arp_pkg::*;
#(
	parameter logic [3:0] MAC_ADDR = 4'd0,
	parameter logic [3:0] IP_ADDR  = 4'd8
) (
	input  logic        clk,
	input  logic        arst_n,
	arp_in_if           rx,
	arp_out_if          tx,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          results_checked,
	output int          results_owed
);

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        run_last;
		logic [47:0] peer_mac;
		logic [31:0] peer_ip;
	} arp_result_t;

	arp_result_t owed_results[$];

	logic [47:0]      cfg_mac;
	logic [31:0]      cfg_ip;
	logic [IDX_W-1:0] byte_pos;
	logic [47:0]      dst_cap;
	logic [15:0]      etype_cap;
	logic [15:0]      op_cap;
	logic [47:0]      smac_cap;
	logic [31:0]      sip_cap;
	logic [31:0]      tip_cap;
	int               mismatch_total;
	int               checked_total;

	// Captures one received byte and, on the last byte of a frame, queues
	// whatever the responder owes for it.
	function automatic void absorb_rx_byte(input logic [7:0] b, input logic last);
		logic [FRAME_MIN*8-1:0] reply;
		arp_result_t            res;
		int                     frame_len;
		if (byte_pos < 6)
			dst_cap = {dst_cap[39:0], b};
		else if (byte_pos == 12 || byte_pos == 13)
			etype_cap = {etype_cap[7:0], b};
		else if (byte_pos == 20 || byte_pos == 21)
			op_cap = {op_cap[7:0], b};
		else if (byte_pos >= 22 && byte_pos < 28)
			smac_cap = {smac_cap[39:0], b};
		else if (byte_pos >= 28 && byte_pos < 32)
			sip_cap = {sip_cap[23:0], b};
		else if (byte_pos >= 38 && byte_pos < 42)
			tip_cap = {tip_cap[23:0], b};

		if (!last) begin
			if (byte_pos != IDX_MAX)
				byte_pos = byte_pos + 1'b1;
			return;
		end

		frame_len = int'(byte_pos) + 1;
		byte_pos = '0;
		if (etype_cap != ETH_TYPE_ARP || frame_len < FRAME_MIN || tip_cap != cfg_ip)
			return;
		if (dst_cap != cfg_mac && dst_cap != MAC_BCAST)
			return;

		if (op_cap == ARP_OP_REQ) begin
			reply = {smac_cap, cfg_mac, ETH_TYPE_ARP, HTYPE_ETH, PTYPE_IPV4, HLEN_ETH,
				PLEN_IPV4, ARP_OP_REPLY, cfg_mac, cfg_ip, smac_cap, sip_cap};
			for (int k = 0; k < FRAME_MIN; k++) begin
				res.kind     = KIND_BYTE;
				res.tx_byte  = reply[(FRAME_MIN - 1 - k) * 8 +: 8];
				res.run_last = (k == FRAME_MIN - 1);
				res.peer_mac = '0;
				res.peer_ip  = '0;
				owed_results.push_back(res);
			end
		end else if (op_cap == ARP_OP_REPLY) begin
			res.kind     = KIND_REPORT;
			res.tx_byte  = '0;
			res.run_last = 1'b1;
			res.peer_mac = smac_cap;
			res.peer_ip  = sip_cap;
			owed_results.push_back(res);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [47:0] want,
			input logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatch_total++;
		end
	endfunction

	function automatic void check_result();
		arp_result_t want;
		if (owed_results.size() == 0) begin
			$display("%0t: unexpected result, kind %0d byte %02h mac %012h ip %08h",
				$time, tx.kind, tx.tx_byte, tx.peer_mac, tx.peer_ip);
			mismatch_total++;
			return;
		end
		want = owed_results.pop_front();
		checked_total++;
		compare_field("kind", 48'(want.kind), 48'(tx.kind));
		compare_field("tx_byte", 48'(want.tx_byte), 48'(tx.tx_byte));
		compare_field("run_last", 48'(want.run_last), 48'(tx.run_last));
		compare_field("peer_mac", want.peer_mac, tx.peer_mac);
		compare_field("peer_ip", 48'(want.peer_ip), 48'(tx.peer_ip));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mac   = '0;
			cfg_ip    = '0;
			byte_pos  = '0;
			dst_cap   = '0;
			etype_cap = '0;
			op_cap    = '0;
			smac_cap  = '0;
			sip_cap   = '0;
			tip_cap   = '0;
			mismatch_total = 0;
			checked_total  = 0;
			owed_results.delete();
			mismatches      <= 0;
			results_checked <= 0;
			results_owed    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == MAC_ADDR)
					cfg_mac = pwdata[47:0];
				else if (paddr == IP_ADDR)
					cfg_ip = pwdata[31:0];
			end
			if (tx.valid && tx.ready)
				check_result();
			if (rx.valid && rx.ready)
				absorb_rx_byte(rx.rx_byte, rx.frame_end);
			mismatches      <= mismatch_total;
			results_checked <= checked_total;
			results_owed    <= owed_results.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Top of the ARP responder bench: clock, reset, frame stimulus, register
// writes and the verdict. Depends on arp_pkg, arp_ifs, arp_checker and the RTL.
module testbench;
	import arp_pkg::*;

	// Register map of the configuration port: 64-bit registers, 8 bytes apart.
	localparam logic [3:0]  ADDR_OWN_MAC = 4'd0;
	localparam logic [3:0]  ADDR_OWN_IP  = 4'd8;
	// Correct hardware and protocol type words; the responder does not check them.
	localparam logic [31:0] ARP_TYPES    = {HTYPE_ETH, PTYPE_IPV4};
	// Cycles allowed after the last owed result for a frame that owes nothing.
	localparam int          QUIET_CYCLES = 8;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          PHASE_BYTES  = 40;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	arp_in_if  rx_ch ();
	arp_out_if tx_ch ();

	int          mismatches;
	int          results_checked;
	int          results_owed;
	int          rx_idle_pct;
	int          tx_idle_pct;
	int          frames_sent;
	int          bytes_sent;
	int          cycles;
	logic [47:0] cur_mac;
	logic [31:0] cur_ip;

	arp_responder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.tx      (tx_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	arp_checker #(
		.MAC_ADDR (ADDR_OWN_MAC),
		.IP_ADDR  (ADDR_OWN_IP)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx              (rx_ch),
		.tx              (tx_ch),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pready          (pready),
		.mismatches      (mismatches),
		.results_checked (results_checked),
		.results_owed    (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The watchdog. A correct run finishes far inside this limit, so reaching
	// it means the responder has hung or is holding back results it owes.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results still owed.",
				cycles, results_owed);
			$display("arp_responder verification failed");
			$finish;
		end
	end

	// The receiver side. Its readiness is redrawn at every falling edge, so
	// stalls land on every stage of a reply run and on the report transfers.
	initial begin
		tx_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tx_ch.ready <= ($urandom_range(99) >= tx_idle_pct);
		end
	end

	// Offers one byte and returns at the falling edge after its transfer.
	// The sender may first sit idle for a random number of cycles.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < rx_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(negedge clk);
		end
		rx_ch.valid     <= 1'b1;
		rx_ch.rx_byte   <= b;
		rx_ch.frame_end <= last;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Sends one frame laid out as an ARP packet over Ethernet. The source MAC
	// and the target hardware address are random, as is any padding beyond
	// the ARP body. A length below 42 cuts the frame short.
	task automatic send_frame(input logic [47:0] dst, input logic [15:0] etype,
			input logic [31:0] types, input logic [15:0] op, input logic [47:0] smac,
			input logic [31:0] sip, input logic [31:0] tip, input int len);
		logic [FRAME_MIN*8-1:0] hdr;
		hdr = {dst, 48'({$urandom(), $urandom()}), etype, types, HLEN_ETH, PLEN_IPV4,
			op, smac, sip, 48'({$urandom(), $urandom()}), tip};
		for (int k = 0; k < len; k++)
			send_byte(k < FRAME_MIN ? hdr[(FRAME_MIN - 1 - k) * 8 +: 8] : 8'($urandom()),
				k == len - 1);
		frames_sent++;
	endtask

	// One register write: a setup cycle, then an access cycle that completes
	// at the rising edge where pready is seen high.
	task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// The upper data bits are filled with noise, since only the low bits of
	// each register are meaningful.
	task automatic set_addresses(input logic [47:0] mac, input logic [31:0] ip);
		write_reg(ADDR_OWN_MAC, {16'($urandom()), mac});
		write_reg(ADDR_OWN_IP, {$urandom(), ip});
		cur_mac = mac;
		cur_ip  = ip;
	endtask

	// Drops valid, waits until every owed result has been seen, then lets a
	// few more cycles pass so that a frame owing nothing is fully judged too.
	task automatic wait_idle();
		rx_ch.valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Random traffic. Most frames are well-formed ARP packets aimed at this
	// station so that requests and replies keep flowing; the rest are
	// misaddressed, mistyped, short or plain noise.
	task automatic random_phase(input int budget);
		int          first_byte;
		int          len;
		int          pick;
		logic [47:0] dst;
		logic [15:0] etype;
		logic [15:0] op;
		logic [31:0] tip;
		logic [47:0] smac;
		logic [31:0] sip;
		first_byte = bytes_sent;
		while (bytes_sent - first_byte < budget) begin
			if ($urandom_range(99) < 12) begin
				len = $urandom_range(60, 1);
				for (int k = 0; k < len; k++)
					send_byte(8'($urandom()), k == len - 1);
				frames_sent++;
			end else begin
				pick  = $urandom_range(99);
				dst   = pick < 45 ? MAC_BCAST : pick < 92 ? cur_mac :
					48'({$urandom(), $urandom()});
				etype = $urandom_range(99) < 92 ? ETH_TYPE_ARP : 16'($urandom());
				pick  = $urandom_range(99);
				op    = pick < 48 ? ARP_OP_REQ : pick < 88 ? ARP_OP_REPLY : 16'($urandom());
				tip   = $urandom_range(99) < 90 ? cur_ip : cur_ip ^ (32'd1 << $urandom_range(31));
				smac  = 48'({$urandom(), $urandom()});
				sip   = $urandom();
				pick  = $urandom_range(99);
				len   = pick < 80 ? $urandom_range(50, 42) :
					pick < 90 ? $urandom_range(41, 20) : $urandom_range(90, 51);
				send_frame(dst, etype, ARP_TYPES, op, smac, sip, tip, len);
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		rx_ch.valid     = 1'b0;
		rx_ch.rx_byte   = '0;
		rx_ch.frame_end = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		rx_idle_pct     = 31;
		tx_idle_pct     = 87;
		frames_sent     = 0;
		bytes_sent      = 0;
		cycles          = 0;
		cur_mac         = '0;
		cur_ip          = '0;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed frames under an ordinary unicast address. Sender pacing is
		// light and the receiver stalls heavily, so jobs wait in the queue.
		set_addresses(48'h02_A1_B2_C3_D4_E5, 32'hC0A8_010A);
		// A broadcast request with an all-zero sender, and a unicast request
		// with all-ones sender fields and two bytes of padding.
		send_frame(MAC_BCAST, ETH_TYPE_ARP, ARP_TYPES, ARP_OP_REQ, 48'h0, 32'h0,
			cur_ip, 42);
		send_frame(cur_mac, ETH_TYPE_ARP, ARP_TYPES, ARP_OP_REQ, '1, '1, cur_ip, 44);
		// A reply gives a single address report.
		send_frame(MAC_BCAST, ETH_TYPE_ARP, ARP_TYPES, ARP_OP_REPLY,
			48'h0A_0B_0C_0D_0E_0F, 32'h0A00_0001, cur_ip, 42);
		// Nonsense hardware and protocol types are not looked at.
		send_frame(MAC_BCAST, ETH_TYPE_ARP, 32'hFFFF_0000, ARP_OP_REQ,
			48'h66_55_44_33_22_11, 32'h0102_0304, cur_ip, 42);
		// The byte-swapped request code is an unknown opcode and is dropped.
		send_frame(MAC_BCAST, ETH_TYPE_ARP, ARP_TYPES, 16'h0100, '1, '1, cur_ip, 42);
		// A request one byte short of the minimum, and a frame of a single byte.
		send_frame(MAC_BCAST, ETH_TYPE_ARP, ARP_TYPES, ARP_OP_REQ, '1, '1, cur_ip, 41);
		send_frame(MAC_BCAST, ETH_TYPE_ARP, ARP_TYPES, ARP_OP_REQ, '1, '1, cur_ip, 1);
		wait_idle();

		// All-zero addresses: a destination of zero is then our own MAC.
		set_addresses(48'h0, 32'h0);
		random_phase(PHASE_BYTES);
		wait_idle();

		// All-ones addresses, where our MAC is the broadcast address, with the
		// pacing of the two sides swapped.
		rx_idle_pct = 87;
		tx_idle_pct = 31;
		set_addresses('1, '1);
		random_phase(PHASE_BYTES);
		wait_idle();

		// Random addresses at full rate on both sides.
		rx_idle_pct = 0;
		tx_idle_pct = 0;
		set_addresses(48'({$urandom(), $urandom()}), $urandom());
		random_phase(PHASE_BYTES);
		wait_idle();

		$display("Sent %0d frames (%0d byte transfers) under four address settings",
			frames_sent, bytes_sent);
		$display("and three pacing mixes; %0d results checked, %0d mismatches.",
			results_checked, mismatches);
		if (mismatches == 0) begin
			$display("arp_responder verification clean");
		end else begin
			$display("arp_responder verification failed");
		end
		$finish;
	end

endmodule
